>>> src/qslerp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qslerp_pkg;

  // fixed point formats
  localparam int FRAC_BITS = 14;
  localparam int Q30_BITS  = 30;

  typedef logic [Q30_BITS:0] q30_t;  // unsigned q30 angle, sine or cosine
  typedef logic [FRAC_BITS:0] frac_t;

  localparam frac_t FRAC_ONE       = frac_t'(1) << FRAC_BITS;
  localparam frac_t LERP_THR_RESET = 15'd16382;

  localparam q30_t Q30_ONE      = q30_t'(1) << Q30_BITS;
  localparam q30_t HALF_PI30    = 31'd1686629713;
  localparam logic [31:0] WEIGHT_CAP = 32'd1 << 31;

  // taylor series of the sine, evaluated horner style from the highest term
  localparam int TAYLOR_TERMS = 6;
  localparam logic [7:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
    8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6
  };

  // reciprocals for the constant divides, corrected by one compare afterwards
  localparam int RECIP_SHIFT = 36;
  localparam logic [63:0] RECIP_SCALE = 64'd1 << RECIP_SHIFT;
  localparam logic [33:0] TAYLOR_RECIP [TAYLOR_TERMS] = '{
    34'(RECIP_SCALE / 64'd156), 34'(RECIP_SCALE / 64'd110),
    34'(RECIP_SCALE / 64'd72),  34'(RECIP_SCALE / 64'd42),
    34'(RECIP_SCALE / 64'd20),  34'(RECIP_SCALE / 64'd6)
  };

  // sine unit: square, three stages per term, final product
  localparam int SIN_LAT = 3 * TAYLOR_TERMS + 2;

  // arc cosine by bisection on the angle, one bit per step
  localparam int ACOS_STEPS = Q30_BITS + 1;
  localparam int ACOS_LAT   = ACOS_STEPS * (SIN_LAT + 1);

  // weight ratio quotient bits
  localparam int DIV_STEPS = Q30_BITS + 1;

endpackage

`default_nettype wire

>>> src/qslerp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface qslerp_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] a_x;
  logic signed [15:0] a_y;
  logic signed [15:0] a_z;
  logic signed [15:0] a_w;
  logic signed [15:0] b_x;
  logic signed [15:0] b_y;
  logic signed [15:0] b_z;
  logic signed [15:0] b_w;
  logic [14:0]        fraction;

  modport source (
    output valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, fraction,
    input  ready
  );
  modport sink (
    input  valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, fraction,
    output ready
  );
endinterface

interface qslerp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [15:0] out_z;
  logic signed [15:0] out_w;

  modport source (
    output valid, out_x, out_y, out_z, out_w,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, out_w,
    output ready
  );
endinterface

`default_nettype wire

>>> src/quaternion_slerp_top.sv
// throughput: one beat per cycle; the whole pipeline halts while an output beat is refused
// the latency is set by the arc cosine: 31 bisection steps of 21 stages, a sine unit plus a pick
// reset (rst_ni low, asynchronous) empties the pipeline and loads lerp_threshold with 16382
`timescale 1ns / 1ps
`default_nettype none

module quaternion_slerp_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        lerp_threshold_we_i,
  input  logic [14:0] lerp_threshold_i,
  qslerp_in_if.sink   in_i,
  qslerp_out_if.source out_o
);

  localparam int SL     = qslerp_pkg::SIN_LAT;
  localparam int AL     = qslerp_pkg::ACOS_LAT;
  localparam int DS     = qslerp_pkg::DIV_STEPS;
  localparam int FB     = qslerp_pkg::FRAC_BITS;
  // positions on the side-data line, counted from the cosine stage
  localparam int P_SIN  = AL + 1 + SL;
  localparam int P_DIV  = P_SIN + 1 + DS;
  localparam int SIDE_LEN  = P_DIV + 3;
  localparam int TOTAL_LAT = P_DIV + 6;
  localparam int W_STAGE   = P_DIV + 3;

  typedef struct packed {
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] a_z;
    logic signed [15:0] a_w;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] b_z;
    logic signed [15:0] b_w;
    qslerp_pkg::frac_t  t;
    logic               neg;   // dot product below zero
    logic               lin;   // cosine at or above threshold
  } side_t;

  // ------------------------------------------------------------------
  // flow control: one stall for the whole pipe, valid bits ride along
  // ------------------------------------------------------------------
  logic                 en;
  logic [TOTAL_LAT-1:0] vld_q;

  assign en         = !vld_q[TOTAL_LAT-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TOTAL_LAT-2:0], in_i.valid};
    end
  end

  // threshold register; the user must write it only while the pipe is empty, the block does not enforce this
  qslerp_pkg::frac_t thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= qslerp_pkg::LERP_THR_RESET;
    end else if (lerp_threshold_we_i) begin
      thr_q <= lerp_threshold_i;
    end
  end

  // ------------------------------------------------------------------
  // stage 1: component products, fraction clamp
  // ------------------------------------------------------------------
  logic signed [31:0] prod_q [4];
  side_t              d1_q;
  side_t              d2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q[0] <= in_i.a_x * in_i.b_x;
      prod_q[1] <= in_i.a_y * in_i.b_y;
      prod_q[2] <= in_i.a_z * in_i.b_z;
      prod_q[3] <= in_i.a_w * in_i.b_w;
      d1_q.a_x  <= in_i.a_x;
      d1_q.a_y  <= in_i.a_y;
      d1_q.a_z  <= in_i.a_z;
      d1_q.a_w  <= in_i.a_w;
      d1_q.b_x  <= in_i.b_x;
      d1_q.b_y  <= in_i.b_y;
      d1_q.b_z  <= in_i.b_z;
      d1_q.b_w  <= in_i.b_w;
      d1_q.t    <= (in_i.fraction > qslerp_pkg::FRAC_ONE) ? qslerp_pkg::FRAC_ONE
                                                          : in_i.fraction;
      d1_q.neg  <= 1'b0;
      d1_q.lin  <= 1'b0;
    end
  end

  // ------------------------------------------------------------------
  // stage 2: dot product sum
  // ------------------------------------------------------------------
  logic signed [33:0] raw_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      raw_q <= 34'(prod_q[0]) + 34'(prod_q[1]) + 34'(prod_q[2]) + 34'(prod_q[3]);
      d2_q  <= d1_q;
    end
  end

  // ------------------------------------------------------------------
  // stage 3: rounded cosine, branch select, arc cosine operand
  // ------------------------------------------------------------------
  logic [32:0]      abs_raw;
  logic [33:0]      cos_sum;
  logic [19:0]      cos_q14;
  qslerp_pkg::q30_t c_next;
  qslerp_pkg::q30_t c_q;
  side_t            side_in;
  side_t            side_q [SIDE_LEN];

  assign abs_raw = raw_q[33] ? 33'(-raw_q) : 33'(raw_q);
  assign cos_sum = {1'b0, abs_raw} + (34'd1 << (FB - 1));
  assign cos_q14 = cos_sum[33:FB];
  // cosine above one is clamped before the arc cosine
  assign c_next  = (cos_q14 > 20'(qslerp_pkg::FRAC_ONE))
                 ? qslerp_pkg::Q30_ONE
                 : qslerp_pkg::q30_t'(cos_q14) << (qslerp_pkg::Q30_BITS - FB);

  always_comb begin
    side_in     = d2_q;
    side_in.neg = raw_q[33];
    side_in.lin = cos_q14 >= 20'(thr_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q       <= c_next;
      side_q[0] <= side_in;
      for (int k = 1; k < SIDE_LEN; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // ------------------------------------------------------------------
  // arc cosine: angle w in q30
  // ------------------------------------------------------------------
  qslerp_pkg::q30_t acos_w;

  qslerp_acos u_acos (
    .clk_i (clk_i),
    .en_i  (en),
    .c_i   (c_q),
    .w_o   (acos_w)
  );

  // ------------------------------------------------------------------
  // split the angle by the fraction: (1-t)w and tw
  // ------------------------------------------------------------------
  logic [45:0]      a0_prod;
  logic [45:0]      a1_prod;
  qslerp_pkg::q30_t e1_w_q;
  qslerp_pkg::q30_t e1_a0_q;
  qslerp_pkg::q30_t e1_a1_q;

  assign a0_prod = 46'(qslerp_pkg::FRAC_ONE - side_q[AL].t) * 46'(acos_w);
  assign a1_prod = 46'(side_q[AL].t) * 46'(acos_w);

  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_w_q  <= acos_w;
      e1_a0_q <= a0_prod[FB +: 31];
      e1_a1_q <= a1_prod[FB +: 31];
    end
  end

  // three sines in parallel: sin(w), sin((1-t)w), sin(tw)
  qslerp_pkg::q30_t sin_s;
  qslerp_pkg::q30_t sin_n0;
  qslerp_pkg::q30_t sin_n1;

  qslerp_sin30 u_sin_s (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (e1_w_q),
    .sin_o (sin_s)
  );

  qslerp_sin30 u_sin_n0 (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (e1_a0_q),
    .sin_o (sin_n0)
  );

  qslerp_sin30 u_sin_n1 (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (e1_a1_q),
    .sin_o (sin_n1)
  );

  // ------------------------------------------------------------------
  // weight ratios: restoring division, one quotient bit per stage
  // a numerator of twice the divisor or more saturates to 2.0
  // ------------------------------------------------------------------
  qslerp_pkg::q30_t dv_s_q   [DS+1];
  logic [31:0]      dv_rem_q [2][DS+1];
  logic [30:0]      dv_quo_q [2][DS+1];
  logic [1:0]       dv_cap_q [DS+1];
  logic             dv_lin_q [DS+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_s_q[0]      <= sin_s;
      dv_rem_q[0][0] <= {1'b0, sin_n0};
      dv_rem_q[1][0] <= {1'b0, sin_n1};
      dv_quo_q[0][0] <= '0;
      dv_quo_q[1][0] <= '0;
      dv_cap_q[0]    <= {{1'b0, sin_n1} >= {sin_s, 1'b0}, {1'b0, sin_n0} >= {sin_s, 1'b0}};
      // zero sine of the angle falls back to linear weights
      dv_lin_q[0]    <= side_q[P_SIN].lin || (sin_s == '0);
    end
  end

  for (genvar j = 0; j < DS; j++) begin : g_div
    for (genvar h = 0; h < 2; h++) begin : g_half
      logic [32:0] trial;
      logic        qbit;

      if (j == 0) begin : g_first
        assign trial = {1'b0, dv_rem_q[h][j]};
      end else begin : g_next
        assign trial = {dv_rem_q[h][j], 1'b0};
      end

      assign qbit = trial >= {2'b0, dv_s_q[j]};

      always_ff @(posedge clk_i) begin
        if (en) begin
          dv_rem_q[h][j+1] <= qbit ? 32'(trial - {2'b0, dv_s_q[j]}) : trial[31:0];
          dv_quo_q[h][j+1] <= {dv_quo_q[h][j][29:0], qbit};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_s_q[j+1]   <= dv_s_q[j];
        dv_cap_q[j+1] <= dv_cap_q[j];
        dv_lin_q[j+1] <= dv_lin_q[j];
      end
    end
  end

  // ------------------------------------------------------------------
  // final weights
  // ------------------------------------------------------------------
  logic [31:0] w0_next;
  logic [31:0] w1_next;
  logic [31:0] e3_w0_q;
  logic [31:0] e3_w1_q;
  logic        e3_lin_q;

  always_comb begin
    if (dv_lin_q[DS]) begin
      w0_next = 32'(qslerp_pkg::FRAC_ONE - side_q[P_DIV].t) << (qslerp_pkg::Q30_BITS - FB);
      w1_next = 32'(side_q[P_DIV].t) << (qslerp_pkg::Q30_BITS - FB);
    end else begin
      w0_next = dv_cap_q[DS][0] ? qslerp_pkg::WEIGHT_CAP : {1'b0, dv_quo_q[0][DS]};
      w1_next = dv_cap_q[DS][1] ? qslerp_pkg::WEIGHT_CAP : {1'b0, dv_quo_q[1][DS]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e3_w0_q  <= w0_next;
      e3_w1_q  <= w1_next;
      e3_lin_q <= dv_lin_q[DS];
    end
  end

  // ------------------------------------------------------------------
  // weighted components
  // ------------------------------------------------------------------
  logic signed [32:0] w0_s;
  logic signed [32:0] w1_s;
  logic signed [48:0] v0_q [4];
  logic signed [48:0] v1_q [4];
  side_t              f1;

  assign w0_s = $signed({1'b0, e3_w0_q});
  assign w1_s = $signed({1'b0, e3_w1_q});
  assign f1   = side_q[P_DIV+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      v0_q[0] <= w0_s * f1.a_x;
      v0_q[1] <= w0_s * f1.a_y;
      v0_q[2] <= w0_s * f1.a_z;
      v0_q[3] <= w0_s * f1.a_w;
      v1_q[0] <= w1_s * f1.b_x;
      v1_q[1] <= w1_s * f1.b_y;
      v1_q[2] <= w1_s * f1.b_z;
      v1_q[3] <= w1_s * f1.b_w;
    end
  end

  // ------------------------------------------------------------------
  // sum, round to nearest (half up), saturate; output registers
  // ------------------------------------------------------------------
  logic signed [15:0] out_q [4];
  logic signed [15:0] sat [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic signed [49:0] v;
      logic signed [49:0] rnd;
      logic signed [19:0] res;
      v   = 50'(v0_q[i]) + (side_q[P_DIV+2].neg ? -50'(v1_q[i]) : 50'(v1_q[i]));
      rnd = v + (50'sd1 <<< (qslerp_pkg::Q30_BITS - 1));
      res = 20'(rnd >>> qslerp_pkg::Q30_BITS);
      if (res > 20'sd32767) begin
        sat[i] = 16'sh7fff;
      end else if (res < -20'sd32768) begin
        sat[i] = -16'sh8000;
      end else begin
        sat[i] = 16'(res);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        out_q[i] <= sat[i];
      end
    end
  end

  assign out_o.valid = vld_q[TOTAL_LAT-1];
  assign out_o.out_x = out_q[0];
  assign out_o.out_y = out_q[1];
  assign out_o.out_z = out_q[2];
  assign out_o.out_w = out_q[3];

  // ------------------------------------------------------------------
  // checks
  // ------------------------------------------------------------------
  // a stalled pipe keeps every valid bit
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("valid bits moved during a stall");

  // arc cosine operand never exceeds one
  a_cos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> c_q <= qslerp_pkg::Q30_ONE)
    else $error("cosine operand above one");

  // weights stay within the cap
  a_weight_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[W_STAGE] |-> (e3_w0_q <= qslerp_pkg::WEIGHT_CAP) &&
                       (e3_w1_q <= qslerp_pkg::WEIGHT_CAP))
    else $error("weight above cap");

  // linear weights add up to one
  a_linear_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[W_STAGE] && e3_lin_q |->
      (33'(e3_w0_q) + 33'(e3_w1_q)) == 33'(qslerp_pkg::Q30_ONE))
    else $error("linear weights do not sum to one");

endmodule

`default_nettype wire

>>> src/qslerp_sin30.sv
`timescale 1ns / 1ps
`default_nettype none

module qslerp_sin30 (
  input  logic               clk_i,
  input  logic               en_i,
  input  qslerp_pkg::q30_t   x_i,
  output qslerp_pkg::q30_t   sin_o
);

  localparam int NT = qslerp_pkg::TAYLOR_TERMS;

  qslerp_pkg::q30_t x0_q;
  logic [31:0]      x20_q;

  qslerp_pkg::q30_t xa_q [NT];
  logic [31:0]      x2a_q [NT];
  logic [31:0]      ya_q [NT];
  qslerp_pkg::q30_t xb_q [NT];
  logic [31:0]      x2b_q [NT];
  logic [31:0]      yb_q [NT];
  logic [29:0]      qb_q [NT];
  qslerp_pkg::q30_t xc_q [NT];
  logic [31:0]      x2c_q [NT];
  qslerp_pkg::q30_t rc_q [NT];

  qslerp_pkg::q30_t sin_q;
  qslerp_pkg::q30_t x_clamp;
  logic [63:0]      sq;
  logic [63:0]      fin;

  // clamp and square
  assign x_clamp = (x_i > qslerp_pkg::HALF_PI30) ? qslerp_pkg::HALF_PI30 : x_i;
  assign sq      = 64'(x_clamp) * 64'(x_clamp);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_q  <= x_clamp;
      x20_q <= sq[61:30];
    end
  end

  for (genvar i = 0; i < NT; i++) begin : g_term
    qslerp_pkg::q30_t r_in;
    qslerp_pkg::q30_t x_in;
    logic [31:0]      x2_in;
    logic [63:0]      p;
    logic [65:0]      m;
    logic [32:0]      back;
    logic [32:0]      rem;
    logic             inc;

    if (i == 0) begin : g_first
      assign r_in  = qslerp_pkg::Q30_ONE;
      assign x_in  = x0_q;
      assign x2_in = x20_q;
    end else begin : g_next
      assign r_in  = rc_q[i-1];
      assign x_in  = xc_q[i-1];
      assign x2_in = x2c_q[i-1];
    end

    assign p    = 64'(x2_in) * 64'(r_in);
    assign m    = 66'(ya_q[i]) * 66'(qslerp_pkg::TAYLOR_RECIP[i]);
    assign back = 33'(qb_q[i]) * 33'(qslerp_pkg::TAYLOR_DIV[i]);
    assign rem  = 33'(yb_q[i]) - back;
    assign inc  = rem >= 33'(qslerp_pkg::TAYLOR_DIV[i]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        // product with running term
        ya_q[i]  <= p[61:30];
        xa_q[i]  <= x_in;
        x2a_q[i] <= x2_in;
        // reciprocal estimate, low by at most one
        qb_q[i]  <= m[qslerp_pkg::RECIP_SHIFT +: 30];
        yb_q[i]  <= ya_q[i];
        xb_q[i]  <= xa_q[i];
        x2b_q[i] <= x2a_q[i];
        // fix up quotient, next running term
        rc_q[i]  <= qslerp_pkg::Q30_ONE - (31'(qb_q[i]) + 31'(inc));
        xc_q[i]  <= xb_q[i];
        x2c_q[i] <= x2b_q[i];
      end
    end
  end

  assign fin = 64'(xc_q[NT-1]) * 64'(rc_q[NT-1]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= fin[60:30];
    end
  end

  assign sin_o = sin_q;

endmodule

`default_nettype wire

>>> src/qslerp_acos.sv
`timescale 1ns / 1ps
`default_nettype none

module qslerp_acos (
  input  logic             clk_i,
  input  logic             en_i,
  input  qslerp_pkg::q30_t c_i,
  output qslerp_pkg::q30_t w_o
);

  localparam int NS = qslerp_pkg::ACOS_STEPS;
  localparam int SL = qslerp_pkg::SIN_LAT;

  qslerp_pkg::q30_t w_q [NS];
  qslerp_pkg::q30_t c_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_step
    localparam qslerp_pkg::q30_t BIT = qslerp_pkg::q30_t'(1) << (NS - 1 - k);

    qslerp_pkg::q30_t w_in;
    qslerp_pkg::q30_t c_in;
    qslerp_pkg::q30_t x;
    qslerp_pkg::q30_t sin_v;
    qslerp_pkg::q30_t cand;
    logic             take;
    qslerp_pkg::q30_t dl_w [SL];
    qslerp_pkg::q30_t dl_c [SL];

    if (k == 0) begin : g_first
      assign w_in = '0;
      assign c_in = c_i;
    end else begin : g_next
      assign w_in = w_q[k-1];
      assign c_in = c_q[k-1];
    end

    // probe the cosine of the candidate angle as sin(pi/2 - angle)
    assign x = qslerp_pkg::HALF_PI30 - (w_in | BIT);

    qslerp_sin30 u_sin (
      .clk_i (clk_i),
      .en_i  (en_i),
      .x_i   (x),
      .sin_o (sin_v)
    );

    assign cand = dl_w[SL-1] | BIT;
    assign take = (cand <= qslerp_pkg::HALF_PI30) && (sin_v >= dl_c[SL-1]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dl_w[0] <= w_in;
        dl_c[0] <= c_in;
        for (int j = 1; j < SL; j++) begin
          dl_w[j] <= dl_w[j-1];
          dl_c[j] <= dl_c[j-1];
        end
        w_q[k] <= take ? cand : dl_w[SL-1];
        c_q[k] <= dl_c[SL-1];
      end
    end
  end

  assign w_o = w_q[NS-1];

endmodule

`default_nettype wire

>>> sim/quaternion_slerp_top_tb.sv
`timescale 1ns / 1ps

module quaternion_slerp_top_tb;

  localparam int                WATCHDOG_LIMIT = 6000;
  localparam int                LONG_HOLD      = 1500;
  localparam longint unsigned   ONE_Q30        = 64'd1 << 30;
  localparam longint unsigned   HALF_PI_Q30    = 64'd1686629713;
  localparam longint unsigned   RATIO_CAP      = 64'd1 << 31;
  localparam longint unsigned   SERIES_DIV [6] = '{156, 110, 72, 42, 20, 6};

  typedef struct {
    shortint    a [4];
    shortint    b [4];
    logic [14:0] t;
  } quat_pair_t;

  typedef struct {
    shortint v [4];
  } quat_t;

  logic clk_i;
  logic rst_ni;
  logic lerp_threshold_we_i;
  logic [14:0] lerp_threshold_i;

  qslerp_in_if  in_i ();
  qslerp_out_if out_o ();

  quaternion_slerp_top u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .lerp_threshold_we_i(lerp_threshold_we_i),
    .lerp_threshold_i   (lerp_threshold_i),
    .in_i               (in_i),
    .out_o              (out_o)
  );

  quat_t       pending_interp [$];
  logic [14:0] thr_shadow;
  int          err_cnt;
  int          beats_in;
  int          beats_checked;
  int          slerp_beats;
  int          linear_beats;
  bit          hold_req;
  int          idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint unsigned sine_q30(longint unsigned x);
    longint unsigned x2;
    longint unsigned r;
    if (x > HALF_PI_Q30) x = HALF_PI_Q30;
    x2 = (x * x) >> 30;
    r  = ONE_Q30;
    for (int i = 0; i < 6; i++) r = ONE_Q30 - ((x2 * r) >> 30) / SERIES_DIV[i];
    return (x * r) >> 30;
  endfunction

  // bisection on the angle, largest first
  function automatic longint unsigned arccos_q30(longint unsigned c);
    longint unsigned ang;
    longint unsigned cand;
    ang = 0;
    for (int b = 30; b >= 0; b--) begin
      cand = ang | (64'd1 << b);
      if (cand <= HALF_PI_Q30 && sine_q30(HALF_PI_Q30 - cand) >= c) ang = cand;
    end
    return ang;
  endfunction

  function automatic longint unsigned capped_ratio(longint unsigned num,
                                                   longint unsigned den);
    longint unsigned q;
    q = (num << 30) / den;
    return (q > RATIO_CAP) ? RATIO_CAP : q;
  endfunction

  function automatic quat_t interpolate(quat_pair_t p, logic [14:0] thr, output bit lin);
    longint          dot;
    longint unsigned mag, cosv, t, w0, w1, c, ang, s;
    longint          s1, v, r;
    quat_t           res;
    dot = 0;
    for (int i = 0; i < 4; i++) dot += longint'(p.a[i]) * longint'(p.b[i]);
    t = p.t;
    if (t > (64'd1 << 14)) t = 64'd1 << 14;
    mag  = (dot < 0) ? longint'(-dot) : longint'(dot);
    cosv = (mag + (64'd1 << 13)) >> 14;
    lin  = (cosv >= thr);
    w0 = 0;
    w1 = 0;
    if (!lin) begin
      c   = (cosv > (64'd1 << 14)) ? (64'd1 << 14) : cosv;
      ang = arccos_q30(c << 16);
      s   = sine_q30(ang);
      if (s == 0) begin
        lin = 1'b1;
      end else begin
        w0 = capped_ratio(sine_q30((((64'd1 << 14) - t) * ang) >> 14), s);
        w1 = capped_ratio(sine_q30((t * ang) >> 14), s);
      end
    end
    if (lin) begin
      w0 = ((64'd1 << 14) - t) << 16;
      w1 = t << 16;
    end
    for (int i = 0; i < 4; i++) begin
      s1 = longint'(w1);
      if (dot < 0) s1 = -s1;
      v = longint'(w0) * longint'(p.a[i]) + s1 * longint'(p.b[i]);
      r = (v + (64'sd1 <<< 29)) >>> 30;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      res.v[i] = shortint'(r);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_beat(quat_pair_t p);
    quat_t exp_q;
    bit    lin;
    in_i.valid    <= 1'b1;
    in_i.a_x      <= p.a[0];
    in_i.a_y      <= p.a[1];
    in_i.a_z      <= p.a[2];
    in_i.a_w      <= p.a[3];
    in_i.b_x      <= p.b[0];
    in_i.b_y      <= p.b[1];
    in_i.b_z      <= p.b[2];
    in_i.b_w      <= p.b[3];
    in_i.fraction <= p.t;
    @(posedge clk_i);
    while (!in_i.ready) @(posedge clk_i);
    exp_q = interpolate(p, thr_shadow, lin);
    pending_interp.push_back(exp_q);
    beats_in++;
    if (lin) linear_beats++;
    else slerp_beats++;
  endtask

  // n must be at least one so valid never gets two updates in one step
  task automatic pause_input(int n);
    in_i.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    pause_input(1);
    while (pending_interp.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [14:0] val);
    lerp_threshold_we_i <= 1'b1;
    lerp_threshold_i    <= val;
    @(posedge clk_i);
    thr_shadow = val;
    lerp_threshold_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic quat_pair_t make_pair(shortint a0, shortint a1, shortint a2, shortint a3,
                                           shortint b0, shortint b1, shortint b2, shortint b3,
                                           logic [14:0] t);
    quat_pair_t p;
    p.a = '{a0, a1, a2, a3};
    p.b = '{b0, b1, b2, b3};
    p.t = t;
    return p;
  endfunction

  // mostly unit-scale quaternions with b near a (or near -a), some raw noise
  function automatic quat_pair_t random_pair();
    quat_pair_t p;
    int         kind, spread;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 4; i++) begin
      if (kind < 2) begin
        p.a[i] = shortint'($urandom);
        p.b[i] = shortint'($urandom);
      end else begin
        p.a[i] = shortint'(int'($urandom_range(0, 16384)) - 8192);
        if (kind >= 8) begin
          p.b[i] = shortint'(int'($urandom_range(0, 16384)) - 8192);
        end else begin
          spread = 1 << $urandom_range(0, 12);
          p.b[i] = shortint'(int'(p.a[i]) + int'($urandom_range(0, 2 * spread)) - spread);
        end
      end
    end
    if (kind >= 2 && $urandom_range(0, 3) == 0)
      for (int i = 0; i < 4; i++) p.b[i] = shortint'(-int'(p.b[i]));
    p.t = ($urandom_range(0, 7) == 0) ? 15'($urandom) : 15'($urandom_range(0, 16384));
    return p;
  endfunction

  // ---------------------------------------------------------------- receiver

  initial begin
    int hold_cnt;
    int duty;
    int tick;
    out_o.ready <= 1'b0;
    duty = 100;
    tick = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        // long refusal so the pipeline fills and stops taking input
        out_o.ready <= 1'b0;
        hold_cnt = 0;
        while (hold_cnt < LONG_HOLD) begin
          @(posedge clk_i);
          hold_cnt++;
        end
        hold_req = 1'b0;
      end
      tick++;
      if (tick % 64 == 0) duty = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(10, 95);
      out_o.ready <= ($urandom_range(0, 99) < duty);
    end
  end

  // ---------------------------------------------------------------- checker

  always @(posedge clk_i) begin
    quat_t e;
    shortint got [4];
    if (rst_ni && out_o.valid && out_o.ready) begin
      got = '{out_o.out_x, out_o.out_y, out_o.out_z, out_o.out_w};
      if (pending_interp.size() == 0) begin
        $display("%0t: unexpected output beat %0d %0d %0d %0d", $time,
                 got[0], got[1], got[2], got[3]);
        err_cnt++;
      end else begin
        e = pending_interp.pop_front();
        for (int i = 0; i < 4; i++)
          if (got[i] !== e.v[i]) begin
            $display("%0t: component %0d expected %0d actual %0d", $time, i, e.v[i], got[i]);
            err_cnt++;
          end
        beats_checked++;
      end
    end
  end

  // watchdog on cycles where no beat moves
  always @(posedge clk_i) begin
    if ((in_i.valid && in_i.ready) || (out_o.valid && out_o.ready) || !rst_ni) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    send_beat(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 15'd0));
    send_beat(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 15'd8192));
    send_beat(make_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                        15'd16384));
    send_beat(make_pair(-32768, 32767, -32768, 32767, 32767, -32768, 32767, -32768, 15'd4096));
    // identical unit quaternions at the fraction ends, then fractions above one
    send_beat(make_pair(0, 0, 0, 16384, 0, 0, 0, 16384, 15'd0));
    send_beat(make_pair(0, 0, 0, 16384, 0, 0, 0, 16384, 15'd16384));
    send_beat(make_pair(0, 0, 0, 16384, 0, 0, 16384, 0, 15'd32767));
    send_beat(make_pair(8192, 8192, 8192, 8192, 8192, 8192, 8192, 8192, 15'd20000));
    // orthogonal pair, cosine zero
    send_beat(make_pair(16384, 0, 0, 0, 0, 16384, 0, 0, 15'd8192));
    send_beat(make_pair(16384, 0, 0, 0, 0, 16384, 0, 0, 15'd1));
    // opposite pair, negative dot flips the second weight
    send_beat(make_pair(0, 0, 0, 16384, 0, 0, 0, -16384, 15'd8192));
    send_beat(make_pair(9000, -3000, 2000, 13000, -9100, 2950, -2010, -12990, 15'd5000));
    // nearly parallel, cosine at or above the reset threshold so the linear weights apply
    send_beat(make_pair(0, 0, 100, 16384, 0, 0, 101, 16384, 15'd16383));
    send_beat(make_pair(0, 0, 300, 16381, 0, 0, 310, 16381, 15'd12000));
    send_beat(make_pair(11585, 0, 0, 11585, 11585, 1, 0, 11584, 15'd3));
    // large components with full fraction range, output saturation
    send_beat(make_pair(32767, -32768, 32767, -32768, 30000, -30000, 100, 0, 15'd16384));
    send_beat(make_pair(-32768, -32768, 0, 0, 32767, -32768, 0, 0, 15'd0));
    send_beat(make_pair(16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 15'd8192));
    drain();
  endtask

  task automatic test_threshold_sweep();
    logic [14:0] settings [5] = '{15'd0, 15'd16384, 15'd32767, 15'd8192, 15'd16000};
    foreach (settings[k]) begin
      write_threshold(settings[k]);
      for (int n = 0; n < 100; n++) begin
        send_beat(random_pair());
        if ($urandom_range(0, 7) == 0) pause_input($urandom_range(1, 10));
      end
      drain();
    end
    write_threshold(qslerp_pkg::LERP_THR_RESET);
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int n = 0; n < 750; n++) send_beat(random_pair());
    drain();
  endtask

  task automatic test_random_bursts();
    int burst;
    for (int n = 0; n < 40; n++) begin
      burst = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      repeat (burst) send_beat(random_pair());
      pause_input($urandom_range(1, 15));
    end
    drain();
  endtask

  initial begin
    err_cnt       = 0;
    beats_in      = 0;
    beats_checked = 0;
    slerp_beats   = 0;
    linear_beats  = 0;
    hold_req      = 1'b0;
    idle_cycles   = 0;
    thr_shadow    = qslerp_pkg::LERP_THR_RESET;
    rst_ni              <= 1'b0;
    lerp_threshold_we_i <= 1'b0;
    lerp_threshold_i    <= '0;
    in_i.valid    <= 1'b0;
    in_i.a_x      <= '0;
    in_i.a_y      <= '0;
    in_i.a_z      <= '0;
    in_i.a_w      <= '0;
    in_i.b_x      <= '0;
    in_i.b_y      <= '0;
    in_i.b_z      <= '0;
    in_i.b_w      <= '0;
    in_i.fraction <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_threshold_sweep();
    test_backpressure();
    test_random_bursts();

    repeat (50) @(posedge clk_i);
    $display("checked %0d of %0d beats: %0d slerp, %0d linear weights", beats_checked,
             beats_in, slerp_beats, linear_beats);
    $display("thresholds swept 0 to 32767, long output stall applied, %0d mismatches",
             err_cnt);
    if (err_cnt == 0 && pending_interp.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
